@@ hw/rtl/covariance_norm_shape_split_top_macros.svh @@
// assertion macros for the covariance norm/shape split block
`ifndef COVARIANCE_NORM_SHAPE_SPLIT_TOP_MACROS_SVH
`define COVARIANCE_NORM_SHAPE_SPLIT_TOP_MACROS_SVH

// checked only while out of reset
`define CNSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// post is checked in the cycle after pre
`define CNSS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/cnss_pkg.sv @@
// shared types, constants and micro-op table of the covariance norm/shape split
package cnss_pkg;

  localparam int unsigned NBINS_DEF = 32;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned BIN_W     = 6;
  localparam logic [BIN_W-1:0] BINS_RST = 6'd32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned TOT_W     = 42;
  localparam int unsigned OUT_W     = 40;
  localparam int unsigned MA_W      = 104;
  localparam int unsigned MB_W      = 42;
  localparam int unsigned DEN_W     = 73;
  localparam int unsigned ACC_W     = 106;
  localparam int unsigned CNT_W     = 7;
  localparam logic [CNT_W-1:0] MUL_STEPS = 7'd42;
  localparam logic [CNT_W-1:0] DIV_STEPS = 7'd104;
  localparam int unsigned UIDX_W    = 4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PRED  = 2'd1,
    OP_MAT   = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_WR,
    S_Q_RD0,
    S_Q_RD1,
    S_EXEC,
    S_WAIT,
    S_FIN
  } state_e;

  typedef enum logic [2:0] {
    U_MUL,
    U_DIV,
    U_ACC,
    U_TSQ,
    U_END
  } ukind_e;

  typedef enum logic [2:0] {
    MS_NJ_RI,
    MS_NI_CJ,
    MS_T_T,
    MS_NI_NJ,
    MS_P_S
  } mul_sel_e;

  typedef enum logic {
    DS_T,
    DS_TSQ
  } div_sel_e;

  typedef enum logic [1:0] {
    AS_A,
    AS_B,
    AS_C
  } acc_sel_e;

  typedef struct packed {
    ukind_e   kind;
    mul_sel_e mul_sel;
    div_sel_e div_sel;
    acc_sel_e acc_sel;
  } uop_t;

  typedef struct packed {
    logic     cap;
    logic     pred_rd_j;
    logic     clear;
    logic     pred_wr;
    logic     mat_wr;
    logic     sums_wr;
    logic     cap_rd0;
    logic     cap_rd1;
    logic     mul_go;
    logic     div_go;
    logic     acc_add;
    logic     tsq_ld;
    mul_sel_e mul_sel;
    div_sel_e div_sel;
    acc_sel_e acc_sel;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic ok_i;
    logic ok_ij;
    logic t_zero;
    logic busy;
    logic out_full;
    logic out_take;
  } sts_t;

  // query micro-program: a, b, then t^2 and the grand-total term
  function automatic uop_t cnss_uop(input logic [UIDX_W-1:0] idx);
    uop_t u;
    u.kind    = U_END;
    u.mul_sel = MS_NJ_RI;
    u.div_sel = DS_T;
    u.acc_sel = AS_A;
    case (idx)
      4'd0:  begin u.kind = U_MUL; u.mul_sel = MS_NJ_RI; end
      4'd1:  begin u.kind = U_DIV; u.div_sel = DS_T;     end
      4'd2:  begin u.kind = U_ACC; u.acc_sel = AS_A;     end
      4'd3:  begin u.kind = U_MUL; u.mul_sel = MS_NI_CJ; end
      4'd4:  begin u.kind = U_DIV; u.div_sel = DS_T;     end
      4'd5:  begin u.kind = U_ACC; u.acc_sel = AS_B;     end
      4'd6:  begin u.kind = U_MUL; u.mul_sel = MS_T_T;   end
      4'd7:  begin u.kind = U_TSQ;                       end
      4'd8:  begin u.kind = U_MUL; u.mul_sel = MS_NI_NJ; end
      4'd9:  begin u.kind = U_MUL; u.mul_sel = MS_P_S;   end
      4'd10: begin u.kind = U_DIV; u.div_sel = DS_TSQ;   end
      4'd11: begin u.kind = U_ACC; u.acc_sel = AS_C;     end
      default: begin u.kind = U_END; end
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/cnss_ram.sv @@
// generic single-write, single-read ram with registered read data
module cnss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cnss_ctrl.sv @@
// controller: item decode and query micro-program sequencer
module cnss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cnss_pkg::sts_t sts_i,
  output cnss_pkg::cmd_t cmd_o
);
  import cnss_pkg::*;

  state_e              state_q, state_d;
  logic [UIDX_W-1:0]   uidx_q, uidx_d;
  uop_t                uop;
  logic                acc;

  assign uop = cnss_uop(uidx_q);
  assign acc = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      uidx_q  <= '0;
    end else begin
      state_q <= state_d;
      uidx_q  <= uidx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    uidx_d  = uidx_q;
    case (state_q)
      S_IDLE: begin
        if (acc && sts_i.ok_ij && (sts_i.op == OP_MAT)) begin
          state_d = S_LD_WR;
        end else if (acc && sts_i.ok_ij && (sts_i.op == OP_QUERY)) begin
          state_d = S_Q_RD0;
        end
      end
      S_LD_WR: state_d = S_IDLE;
      S_Q_RD0: state_d = S_Q_RD1;
      S_Q_RD1: begin
        uidx_d  = '0;
        state_d = sts_i.t_zero ? S_FIN : S_EXEC;
      end
      S_EXEC: begin
        case (uop.kind)
          U_MUL, U_DIV: state_d = S_WAIT;
          U_ACC, U_TSQ: uidx_d = uidx_q + 1'b1;
          default:      state_d = S_FIN;
        endcase
      end
      S_WAIT: begin
        if (!sts_i.busy) begin
          state_d = S_EXEC;
          uidx_d  = uidx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!sts_i.out_full || sts_i.out_take) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = uop.mul_sel;
    cmd_o.div_sel = uop.div_sel;
    cmd_o.acc_sel = uop.acc_sel;
    in_stall_o    = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.cap = 1'b1;
          case (sts_i.op)
            OP_CLEAR: cmd_o.clear   = 1'b1;
            OP_PRED:  cmd_o.pred_wr = sts_i.ok_i;
            OP_MAT:   cmd_o.mat_wr  = sts_i.ok_ij;
            default:  ;
          endcase
        end
      end
      S_LD_WR: cmd_o.sums_wr = 1'b1;
      S_Q_RD0: begin
        cmd_o.cap_rd0   = 1'b1;
        cmd_o.pred_rd_j = 1'b1;
      end
      S_Q_RD1: cmd_o.cap_rd1 = 1'b1;
      S_EXEC: begin
        case (uop.kind)
          U_MUL:   cmd_o.mul_go  = 1'b1;
          U_DIV:   cmd_o.div_go  = 1'b1;
          U_ACC:   cmd_o.acc_add = 1'b1;
          U_TSQ:   cmd_o.tsq_ld  = 1'b1;
          default: ;
        endcase
      end
      S_FIN: cmd_o.out_ld = !sts_i.out_full || sts_i.out_take;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/cnss_dp.sv @@
// datapath: stores, running sums, serial multiplier and divider, result register
module cnss_dp #(
  parameter int unsigned NBINS = cnss_pkg::NBINS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cnss_pkg::BIN_W-1:0]        cfg_wdata_i,
  input  logic [1:0]                        operation_i,
  input  logic [cnss_pkg::IDX_W-1:0]        row_i,
  input  logic [cnss_pkg::IDX_W-1:0]        col_i,
  input  logic signed [cnss_pkg::VAL_W-1:0] value_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [cnss_pkg::IDX_W-1:0]        out_row_o,
  output logic [cnss_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [cnss_pkg::OUT_W-1:0] norm_mixed_part_o,
  output logic signed [cnss_pkg::OUT_W-1:0] shape_part_o,
  output logic [1:0]                        status_o,
  input  cnss_pkg::cmd_t                    cmd_i,
  output cnss_pkg::sts_t                    sts_o
);
  import cnss_pkg::*;

  localparam int unsigned IW  = $clog2(NBINS);
  localparam int unsigned MAW = $clog2(NBINS * NBINS);

  // configuration and totals
  logic [BIN_W-1:0] bins_q;
  logic [SUM_W-1:0] t_q;
  logic [TOT_W-1:0] s_q;
  logic [NBINS-1:0] rvld_q, cvld_q;
  logic             rvld_rd_q, cvld_rd_q;

  // item and operand registers
  logic [IDX_W-1:0] i_q, j_q;
  logic [VAL_W-1:0] v_q, ni_q, nj_q, mij_q;
  logic [SUM_W-1:0] ri_q, cj_q;

  // arithmetic unit
  logic             busy_q, is_div_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MA_W-1:0]  mula_q, prod_q;
  logic [MB_W-1:0]  mulb_q;
  logic [DEN_W-1:0] den_q, rem_q, tsq_q;
  logic [ACC_W-1:0] acc_q;

  // result register
  logic             ovld_q;
  logic [IDX_W-1:0] orow_q, ocol_q;
  logic [OUT_W-1:0] onm_q, osh_q;
  logic [1:0]       ost_q;

  logic [8:0]       lim, i9, j9, iq9, jq9;
  logic [15:0]      mad;
  logic [IW-1:0]    pred_raddr;
  logic [VAL_W-1:0] pred_rd, mat_rd;
  logic [SUM_W-1:0] row_rd, col_rd, row_new, col_new, v_ext;
  logic [VAL_W-1:0] ni_mag, nj_mag;
  logic [SUM_W-1:0] ri_mag, cj_mag, t_mag;
  logic [TOT_W-1:0] s_mag;
  logic [MA_W-1:0]  sel_a;
  logic [MB_W-1:0]  sel_b;
  logic [DEN_W-1:0] sel_den;
  logic [DEN_W:0]   r2, diff;
  logic             ge, neg;
  logic [ACC_W-1:0] q_ext, sh;
  logic             nm_fit, sh_fit, take;

  assign i9  = {4'b0, row_i};
  assign j9  = {4'b0, col_i};
  assign iq9 = {4'b0, i_q};
  assign jq9 = {4'b0, j_q};
  assign lim = ({3'b0, bins_q} < 9'(NBINS)) ? {3'b0, bins_q} : 9'(NBINS);
  assign mad = 16'(i9) * 16'(NBINS) + 16'(j9);
  assign pred_raddr = cmd_i.pred_rd_j ? jq9[IW-1:0] : i9[IW-1:0];

  cnss_ram #(.WIDTH(VAL_W), .DEPTH(NBINS)) u_pred (
    .clk_i, .we_i(cmd_i.pred_wr), .waddr_i(i9[IW-1:0]), .wdata_i(value_i),
    .raddr_i(pred_raddr), .rdata_o(pred_rd)
  );
  cnss_ram #(.WIDTH(VAL_W), .DEPTH(NBINS * NBINS)) u_mat (
    .clk_i, .we_i(cmd_i.mat_wr), .waddr_i(mad[MAW-1:0]), .wdata_i(value_i),
    .raddr_i(mad[MAW-1:0]), .rdata_o(mat_rd)
  );
  cnss_ram #(.WIDTH(SUM_W), .DEPTH(NBINS)) u_rsum (
    .clk_i, .we_i(cmd_i.sums_wr), .waddr_i(iq9[IW-1:0]), .wdata_i(row_new),
    .raddr_i(i9[IW-1:0]), .rdata_o(row_rd)
  );
  cnss_ram #(.WIDTH(SUM_W), .DEPTH(NBINS)) u_csum (
    .clk_i, .we_i(cmd_i.sums_wr), .waddr_i(jq9[IW-1:0]), .wdata_i(col_new),
    .raddr_i(j9[IW-1:0]), .rdata_o(col_rd)
  );

  // entries without a valid bit read as zero
  assign v_ext   = {{(SUM_W-VAL_W){v_q[VAL_W-1]}}, v_q};
  assign row_new = (rvld_rd_q ? row_rd : '0) + v_ext;
  assign col_new = (cvld_rd_q ? col_rd : '0) + v_ext;

  assign ni_mag = ni_q[VAL_W-1] ? -ni_q : ni_q;
  assign nj_mag = nj_q[VAL_W-1] ? -nj_q : nj_q;
  assign ri_mag = ri_q[SUM_W-1] ? -ri_q : ri_q;
  assign cj_mag = cj_q[SUM_W-1] ? -cj_q : cj_q;
  assign t_mag  = t_q[SUM_W-1]  ? -t_q  : t_q;
  assign s_mag  = s_q[TOT_W-1]  ? -s_q  : s_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_NJ_RI: begin sel_a = MA_W'(nj_mag); sel_b = MB_W'(ri_mag); end
      MS_NI_CJ: begin sel_a = MA_W'(ni_mag); sel_b = MB_W'(cj_mag); end
      MS_T_T:   begin sel_a = MA_W'(t_mag);  sel_b = MB_W'(t_mag);  end
      MS_NI_NJ: begin sel_a = MA_W'(ni_mag); sel_b = MB_W'(nj_mag); end
      MS_P_S:   begin sel_a = prod_q;        sel_b = s_mag;         end
      default:  begin sel_a = '0;            sel_b = '0;            end
    endcase
    case (cmd_i.div_sel)
      DS_T:    sel_den = DEN_W'(t_mag);
      default: sel_den = tsq_q;
    endcase
    case (cmd_i.acc_sel)
      AS_A:    neg = nj_q[VAL_W-1] ^ ri_q[SUM_W-1] ^ t_q[SUM_W-1];
      AS_B:    neg = ni_q[VAL_W-1] ^ cj_q[SUM_W-1] ^ t_q[SUM_W-1];
      default: neg = ~(ni_q[VAL_W-1] ^ nj_q[VAL_W-1] ^ s_q[TOT_W-1]);
    endcase
  end

  // restoring division step, quotient shifts into prod
  assign r2    = {rem_q, prod_q[MA_W-1]};
  assign diff  = r2 - {1'b0, den_q};
  assign ge    = (r2 >= {1'b0, den_q});
  assign q_ext = ACC_W'(prod_q);

  assign sh     = {{(ACC_W-VAL_W){mij_q[VAL_W-1]}}, mij_q} - acc_q;
  assign nm_fit = (&acc_q[ACC_W-1:OUT_W-1]) | ~(|acc_q[ACC_W-1:OUT_W-1]);
  assign sh_fit = (&sh[ACC_W-1:OUT_W-1]) | ~(|sh[ACC_W-1:OUT_W-1]);
  assign take   = ovld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q   <= BINS_RST;
      t_q      <= '0;
      s_q      <= '0;
      rvld_q   <= '0;
      cvld_q   <= '0;
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      cnt_q    <= '0;
      ovld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bins_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        t_q    <= '0;
        s_q    <= '0;
        rvld_q <= '0;
        cvld_q <= '0;
      end else begin
        if (cmd_i.pred_wr) begin
          t_q <= t_q + {{(SUM_W-VAL_W){value_i[VAL_W-1]}}, value_i};
        end
        if (cmd_i.mat_wr) begin
          s_q <= s_q + {{(TOT_W-VAL_W){value_i[VAL_W-1]}}, value_i};
        end
        if (cmd_i.sums_wr) begin
          rvld_q[iq9[IW-1:0]] <= 1'b1;
          cvld_q[jq9[IW-1:0]] <= 1'b1;
        end
      end
      if (cmd_i.mul_go || cmd_i.div_go) begin
        busy_q   <= 1'b1;
        is_div_q <= cmd_i.div_go;
        cnt_q    <= cmd_i.div_go ? DIV_STEPS : MUL_STEPS;
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 1'b1;
        busy_q <= (cnt_q != 7'd1);
      end
      if (cmd_i.out_ld) begin
        ovld_q <= 1'b1;
      end else if (take) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rvld_rd_q <= rvld_q[i9[IW-1:0]];
    cvld_rd_q <= cvld_q[j9[IW-1:0]];
    if (cmd_i.cap) begin
      i_q <= row_i;
      j_q <= col_i;
      v_q <= value_i;
    end
    if (cmd_i.cap_rd0) begin
      ni_q  <= pred_rd;
      ri_q  <= rvld_rd_q ? row_rd : '0;
      cj_q  <= cvld_rd_q ? col_rd : '0;
      mij_q <= mat_rd;
    end
    if (cmd_i.cap_rd1) begin
      nj_q  <= pred_rd;
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + (neg ? -q_ext : q_ext);
    end
    if (cmd_i.tsq_ld) begin
      tsq_q <= prod_q[DEN_W-1:0];
    end
    if (cmd_i.mul_go) begin
      mula_q <= sel_a;
      mulb_q <= sel_b;
      prod_q <= '0;
    end else if (cmd_i.div_go) begin
      den_q <= sel_den;
      rem_q <= '0;
    end else if (busy_q && !is_div_q) begin
      if (mulb_q[0]) begin
        prod_q <= prod_q + mula_q;
      end
      mula_q <= {mula_q[MA_W-2:0], 1'b0};
      mulb_q <= {1'b0, mulb_q[MB_W-1:1]};
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      prod_q <= {prod_q[MA_W-2:0], ge};
    end
    if (cmd_i.out_ld) begin
      orow_q <= i_q;
      ocol_q <= j_q;
      if (t_q == '0) begin
        onm_q <= '0;
        osh_q <= '0;
        ost_q <= ST_ZERO;
      end else begin
        onm_q <= nm_fit ? acc_q[OUT_W-1:0] :
                 (acc_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});
        osh_q <= sh_fit ? sh[OUT_W-1:0] :
                 (sh[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});
        ost_q <= (nm_fit && sh_fit) ? ST_OK : ST_SAT;
      end
    end
  end

  assign out_valid_o       = ovld_q;
  assign out_row_o         = orow_q;
  assign out_col_o         = ocol_q;
  assign norm_mixed_part_o = onm_q;
  assign shape_part_o      = osh_q;
  assign status_o          = ost_q;

  assign sts_o.op       = op_e'(operation_i);
  assign sts_o.ok_i     = (i9 < lim);
  assign sts_o.ok_ij    = (i9 < lim) && (j9 < lim);
  assign sts_o.t_zero   = (t_q == '0);
  assign sts_o.busy     = busy_q;
  assign sts_o.out_full = ovld_q;
  assign sts_o.out_take = take;

endmodule

@@ hw/rtl/covariance_norm_shape_split_top.sv @@
// top level of the covariance norm/shape split block
// Splits a covariance matrix into a normalisation-plus-mixed part and a shape part from
// per-bin predictions. Clear and prediction-load beats finish in the accepting state; a
// matrix-load beat adds a write state (read-modify-write of the row and column sums). A
// query runs two store read states, then five products on a shift-add multiplier at one
// multiplier bit per cycle (42 steps each), three quotients on a restoring divider at one
// quotient bit per cycle (104 steps each), three accumulate steps, one t^2 load, one
// end-of-program step and one result load, sequenced one item at a time. A query whose
// prediction total is zero goes from its store reads straight to the result load. The
// result register lets the next beat in while a result waits; a query reaching its result
// load while the previous result is still stalled waits for that result to be taken.
`include "covariance_norm_shape_split_top_macros.svh"

module covariance_norm_shape_split_top #(
  parameter int unsigned NBINS = cnss_pkg::NBINS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: bins in use
  input  logic                              cfg_we_i,
  input  logic [cnss_pkg::BIN_W-1:0]        cfg_wdata_i,
  // input beats
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [cnss_pkg::IDX_W-1:0]        row_i,
  input  logic [cnss_pkg::IDX_W-1:0]        col_i,
  input  logic signed [cnss_pkg::VAL_W-1:0] value_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cnss_pkg::IDX_W-1:0]        out_row_o,
  output logic [cnss_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [cnss_pkg::OUT_W-1:0] norm_mixed_part_o,
  output logic signed [cnss_pkg::OUT_W-1:0] shape_part_o,
  output logic [1:0]                        status_o
);
  import cnss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes beats and steps the query micro-program
  cnss_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // stores, sums, arithmetic and result register
  cnss_dp #(.NBINS(NBINS)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .operation_i,
    .row_i,
    .col_i,
    .value_i,
    .out_stall_i,
    .out_valid_o,
    .out_row_o,
    .out_col_o,
    .norm_mixed_part_o,
    .shape_part_o,
    .status_o,
    .cmd_i (cmd),
    .sts_o (sts)
  );

  // a result is never written over one still waiting
  `CNSS_ASSERT(a_no_overwrite, cmd.out_ld |-> (!out_valid_o || !out_stall_i), "result overwritten")
  // the serial unit is never restarted mid-operation
  `CNSS_ASSERT(a_no_restart, (cmd.mul_go || cmd.div_go) |-> !sts.busy, "arith unit restarted")
  // a zero prediction total gives zero parts
  `CNSS_ASSERT(a_zero_parts, (out_valid_o && (status_o == ST_ZERO)) |->
    ((norm_mixed_part_o == '0) && (shape_part_o == '0)), "zero total with nonzero parts")
  // a load command is always followed by a valid result
  `CNSS_ASSERT_NEXT(a_load_shows, cmd.out_ld, out_valid_o, "loaded result not shown")

endmodule

@@ bench/covariance_norm_shape_split_top_tb.sv @@
// self-checking testbench for the covariance norm/shape split top level
module covariance_norm_shape_split_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cnss_pkg::*;

  localparam int unsigned NB         = 32;
  localparam int unsigned ITEM_GOAL  = 1600;
  localparam int unsigned STALL_LIMIT = 20000;  // watchdog limit on quiet cycles
  localparam int unsigned SETTLE     = 16;      // idle time added after the last expected result is taken

  typedef logic [IDX_W-1:0] bin_t;

  // one cell answer as the block should report it
  typedef struct packed {
    bin_t                     row;
    bin_t                     col;
    logic signed [OUT_W-1:0]  norm_mixed;
    logic signed [OUT_W-1:0]  shape;
    status_e                  status;
  } cell_answer_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [BIN_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                operation_i;
  bin_t                      row_i;
  bin_t                      col_i;
  logic signed [VAL_W-1:0]   value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  bin_t                      out_row_o;
  bin_t                      out_col_o;
  logic signed [OUT_W-1:0]   norm_mixed_part_o;
  logic signed [OUT_W-1:0]   shape_part_o;
  logic [1:0]                status_o;

  covariance_norm_shape_split_top #(.NBINS(NB)) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_row_o         (out_row_o),
    .out_col_o         (out_col_o),
    .norm_mixed_part_o (norm_mixed_part_o),
    .shape_part_o      (shape_part_o),
    .status_o          (status_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // shadow copy of the block state
  logic signed [VAL_W-1:0] pred_shadow [NB];
  logic signed [VAL_W-1:0] cov_shadow  [NB][NB];
  bit                      pred_loaded [NB];
  bit                      cov_loaded  [NB][NB];
  logic [SUM_W-1:0]        row_total   [NB];
  logic [SUM_W-1:0]        col_total   [NB];
  logic [TOT_W-1:0]        grand_total;
  logic [SUM_W-1:0]        pred_total;
  int unsigned             bins_cfg;

  cell_answer_t pending_answers [$];
  int unsigned  errors;
  int unsigned  items_sent;
  int unsigned  burst_left;

  // clamp to 40-bit Q24.16, flag when clamped
  function automatic logic signed [OUT_W-1:0] clamp40(input logic signed [255:0] v,
                                                     inout bit hit);
    if (v > 256'sd549755813887) begin
      hit = 1'b1;
      return 40'sh7FFFFFFFFF;
    end
    if (v < -256'sd549755813888) begin
      hit = 1'b1;
      return 40'sh8000000000;
    end
    return v[OUT_W-1:0];
  endfunction

  // norm-plus-mixed and shape parts of cell (i,j) from the shadow state
  function automatic cell_answer_t split_cell(input int unsigned i, input int unsigned j);
    cell_answer_t ans;
    logic signed [255:0] ni, nj, ri, cj, s, t, a, b, c, nm, sh;
    bit hit;
    ans.row = bin_t'(i);
    ans.col = bin_t'(j);
    ans.norm_mixed = '0;
    ans.shape = '0;
    ans.status = ST_ZERO;
    if (pred_total == '0) return ans;
    ni = pred_shadow[i];
    nj = pred_shadow[j];
    ri = $signed(row_total[i]);
    cj = $signed(col_total[j]);
    s  = $signed(grand_total);
    t  = $signed(pred_total);
    // each term truncates toward zero on its own
    a  = (nj * ri) / t;
    b  = (ni * cj) / t;
    c  = (ni * nj * s) / (t * t);
    nm = a + b - c;
    sh = cov_shadow[i][j];
    sh = sh - nm;
    hit = 1'b0;
    ans.norm_mixed = clamp40(nm, hit);
    ans.shape = clamp40(sh, hit);
    ans.status = hit ? ST_SAT : ST_OK;
    return ans;
  endfunction

  // update the shadow state for one accepted beat
  task automatic absorb_beat(input op_e op, input bin_t r, input bin_t c,
                             input logic signed [VAL_W-1:0] v);
    int unsigned lim;
    lim = (bins_cfg < NB) ? bins_cfg : NB;
    if (op == OP_CLEAR) begin
      foreach (row_total[k]) begin
        row_total[k] = '0;
        col_total[k] = '0;
      end
      grand_total = '0;
      pred_total = '0;
    end else if (r < lim) begin
      if (op == OP_PRED) begin
        pred_shadow[r] = v;
        pred_loaded[r] = 1'b1;
        pred_total = pred_total + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
      end else if (c < lim) begin
        if (op == OP_MAT) begin
          cov_shadow[r][c] = v;
          cov_loaded[r][c] = 1'b1;
          row_total[r] = row_total[r] + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
          col_total[c] = col_total[c] + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
          grand_total = grand_total + {{(TOT_W-VAL_W){v[VAL_W-1]}}, v};
        end else begin
          pending_answers.push_back(split_cell(r, c));
        end
      end
    end
  endtask

  // drive one beat, honouring the burst/gap pattern, and wait for it to be taken
  task automatic send_beat(input op_e op, input int unsigned r, input int unsigned c,
                           input logic signed [VAL_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i  = 1'b1;
    operation_i = op;
    row_i       = bin_t'(r);
    col_i       = bin_t'(c);
    value_i     = v;
    do @(posedge clk_i); while (in_stall_o);
    absorb_beat(op, bin_t'(r), bin_t'(c), v);
    items_sent++;
    @(negedge clk_i);
  endtask

  // let the block drain completely
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_bins(input int unsigned n);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = BIN_W'(n);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    bins_cfg    = n;
  endtask

  // half small values so results stay in range, the rest full-range and corners
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return $signed($urandom_range(0, 1 << 21)) - 32'sd1048576;
    if (k < 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  // query a cell, loading its matrix entry first if it was never written
  task automatic query_cell(input int unsigned i, input int unsigned j);
    if (!cov_loaded[i][j]) send_beat(OP_MAT, i, j, pick_value());
    send_beat(OP_QUERY, i, j, $urandom);
  endtask

  // two-bin grid with corner values, ignored indices, reload and a zero total
  task automatic test_corner_grid();
    write_bins(2);
    send_beat(OP_CLEAR, 0, 0, 32'sd0);
    send_beat(OP_PRED, 0, 31, 32'sh7FFFFFFF);
    send_beat(OP_PRED, 1, 0, 32'sh80000000);
    send_beat(OP_MAT, 0, 0, 32'sh7FFFFFFF);
    send_beat(OP_MAT, 0, 1, 32'sh80000000);
    send_beat(OP_MAT, 1, 0, 32'sd0);
    send_beat(OP_MAT, 1, 1, 32'sd1);
    send_beat(OP_QUERY, 0, 0, 32'sd0);
    send_beat(OP_QUERY, 1, 1, 32'sd0);
    // indices at or past the limit are dropped
    send_beat(OP_PRED, 31, 0, 32'sh12345678);
    send_beat(OP_MAT, 0, 5, 32'sh0000FFFF);
    send_beat(OP_QUERY, 2, 0, 32'sd0);
    send_beat(OP_QUERY, 0, 31, 32'sd0);
    // reload replaces the entry, the totals add the new value on top
    send_beat(OP_PRED, 0, 0, 32'sh00010000);
    send_beat(OP_MAT, 1, 0, -32'sh00020000);
    send_beat(OP_QUERY, 0, 1, 32'sd0);
    send_beat(OP_QUERY, 1, 0, 32'sd0);
    // cleared totals but kept entries
    send_beat(OP_CLEAR, 0, 0, 32'sd0);
    send_beat(OP_QUERY, 1, 1, 32'sd0);
  endtask

  // one-bin limit
  task automatic test_single_bin();
    write_bins(1);
    send_beat(OP_CLEAR, 0, 0, 32'sd0);
    send_beat(OP_PRED, 0, 0, 32'sh00030000);
    send_beat(OP_MAT, 0, 0, 32'sh00050000);
    send_beat(OP_QUERY, 0, 0, 32'sd0);
    send_beat(OP_QUERY, 1, 1, 32'sd0);
  endtask

  // random sequences: clear, predictions, matrix entries, queries, plus noise
  task automatic test_random_phase(input int unsigned n, input int unsigned goal);
    int unsigned lim, i, j, x;
    logic signed [VAL_W-1:0] v;
    write_bins(n);
    lim = (n < NB) ? n : NB;
    // make sure every prediction in range exists before any query
    for (int unsigned k = 0; k < lim; k++)
      if (!pred_loaded[k]) send_beat(OP_PRED, k, $urandom_range(0, 31), pick_value());
    while (items_sent < goal) begin
      x = $urandom_range(0, 19);
      if (x == 0) begin
        send_beat(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
      end else if (x < 4) begin
        // fresh totals: clear then a full set of predictions
        send_beat(OP_CLEAR, 0, 0, 32'sd0);
        for (int unsigned k = 0; k < lim; k++)
          send_beat(OP_PRED, k, $urandom_range(0, 31), pick_value());
      end else if (x == 4) begin
        // predictions v and -v, a zero total unless v is the most negative value
        send_beat(OP_CLEAR, 0, 0, 32'sd0);
        v = pick_value();
        i = $urandom_range(0, lim - 1);
        send_beat(OP_PRED, i, 0, v);
        send_beat(OP_PRED, $urandom_range(0, lim - 1), 0, -v);
      end else if (x < 10) begin
        for (int unsigned k = $urandom_range(1, 8); k > 0; k--)
          send_beat(OP_MAT, $urandom_range(0, lim - 1), $urandom_range(0, lim - 1),
                    pick_value());
      end else if (x < 17) begin
        query_cell($urandom_range(0, lim - 1), $urandom_range(0, lim - 1));
      end else begin
        // noise: indices past the limit with a prediction, matrix or query operation, or a plain prediction
        i = $urandom_range(0, 31);
        j = $urandom_range(0, 31);
        if (i >= lim || j >= lim || $urandom_range(0, 1) == 0) begin
          if (i < lim && j < lim) j = (lim < NB) ? $urandom_range(lim, 31) : j;
          if (i < lim && j < lim) send_beat(OP_PRED, i, j, $urandom);
          else send_beat(op_e'($urandom_range(1, 3)), i, j, $urandom);
        end else begin
          send_beat(OP_PRED, i, j, pick_value());
        end
      end
    end
  endtask

  // result checker: compare each taken result beat with the oldest expectation
  always @(posedge clk_i) begin
    cell_answer_t exp_ans;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat row %0d col %0d", $time, out_row_o, out_col_o);
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_row_o !== exp_ans.row) begin
          errors++;
          $display("%0t: out_row expected %0d actual %0d", $time, exp_ans.row, out_row_o);
        end
        if (out_col_o !== exp_ans.col) begin
          errors++;
          $display("%0t: out_col expected %0d actual %0d", $time, exp_ans.col, out_col_o);
        end
        if (norm_mixed_part_o !== exp_ans.norm_mixed) begin
          errors++;
          $display("%0t: norm_mixed_part expected %0d actual %0d", $time,
                   exp_ans.norm_mixed, norm_mixed_part_o);
        end
        if (shape_part_o !== exp_ans.shape) begin
          errors++;
          $display("%0t: shape_part expected %0d actual %0d", $time,
                   exp_ans.shape, shape_part_o);
        end
        if (status_o !== exp_ans.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.status, status_o);
        end
      end
    end
  end

  // receiver stall pattern: switches between no stall, random and long runs
  int unsigned stall_mode;
  int unsigned stall_tick;
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= ((stall_tick % 24) < 15);
    endcase
  end

  // watchdog on cycles without any accepted input beat or taken result beat
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_CLEAR;
    row_i       = '0;
    col_i       = '0;
    value_i     = '0;
    out_stall_i = 1'b0;
    stall_mode  = 0;
    stall_tick  = 0;
    quiet_cycles = 0;
    errors      = 0;
    items_sent  = 0;
    burst_left  = 0;
    bins_cfg    = BINS_RST;
    grand_total = '0;
    pred_total  = '0;
    foreach (row_total[k]) begin
      row_total[k]   = '0;
      col_total[k]   = '0;
      pred_loaded[k] = 1'b0;
      pred_shadow[k] = '0;
      foreach (cov_loaded[k][m]) begin
        cov_loaded[k][m] = 1'b0;
        cov_shadow[k][m] = '0;
      end
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_grid();
    test_single_bin();
    test_random_phase(32, 400);
    test_random_phase($urandom_range(3, 31), 750);
    test_random_phase(1, 850);
    test_random_phase($urandom_range(2, 8), 1150);
    test_random_phase(32, ITEM_GOAL);

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cnss_pkg.sv
hw/rtl/cnss_ram.sv
hw/rtl/cnss_ctrl.sv
hw/rtl/cnss_dp.sv
hw/rtl/covariance_norm_shape_split_top.sv
bench/covariance_norm_shape_split_top_tb.sv
